// ----- hw/rtl/msd_pkg.sv -----
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, constants and helpers for the multiplexed switch scanner
// with per-channel debounce.
// ----------------------------------------------------------------------------
package msd_pkg;

  // scan geometry
  localparam int MUX_PINS      = 8;
  localparam int SELECT_STATES = 4;
  localparam int CHANNELS      = MUX_PINS * SELECT_STATES;
  localparam int PIN_BITS      = $clog2(MUX_PINS);
  localparam int SEL_BITS      = $clog2(SELECT_STATES);
  localparam int CH_BITS       = $clog2(CHANNELS);

  // timer and register widths
  localparam int TIMER_BITS    = 20;
  localparam int CFG_BITS      = 20;
  localparam int CFG_IDX_BITS  = 2;
  localparam int WIDE_BITS     = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  localparam logic [WIDE_BITS-1:0] TIMER_MAX =
    WIDE_BITS'((64'd1 << TIMER_BITS) - 64'd1);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TICK_TIME = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN  = CFG_IDX_BITS'(1);

  // register reset values
  localparam logic [CFG_BITS-1:0] TICK_TIME_RESET = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] COOLDOWN_RESET  = CFG_BITS'(20000);

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_BITS-1:0]   cfg_word_t;
  typedef logic [CH_BITS-1:0]    ch_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_PINS,
    ST_FINISH
  } msd_state_t;

  // shared timer unit operations
  typedef enum logic {
    TOP_DEC,
    TOP_LOAD
  } msd_timer_op_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic    in_ready;
    logic    sweep;
    logic    pin;
    logic    load;
    ch_idx_t idx;
  } msd_ctrl_t;

  // pin/select to channel remap, indexed by {pin, select}
  localparam logic [CH_BITS-1:0] REMAP [CHANNELS] = '{
    5'd2,  5'd1,  5'd0,  5'd3,  5'd7,  5'd4,  5'd6,  5'd5,
    5'd15, 5'd12, 5'd14, 5'd13, 5'd10, 5'd9,  5'd8,  5'd11,
    5'd31, 5'd28, 5'd30, 5'd29, 5'd26, 5'd25, 5'd24, 5'd27,
    5'd23, 5'd20, 5'd22, 5'd21, 5'd18, 5'd17, 5'd16, 5'd19
  };

  // reload value saturated to the timer width
  function automatic timer_t clamp_timer(input cfg_word_t v);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(v);
    if (w > TIMER_MAX) begin
      return TIMER_MAX[TIMER_BITS-1:0];
    end
    return w[TIMER_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/msd_in_if.sv -----
// ----------------------------------------------------------------------------
// msd_in_if
// Scan tick channel: one transaction carries the sampled mux pin levels.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_pins;

  modport source (output valid, output raw_pins, input ready);
  modport sink   (input valid, input raw_pins, output ready);
endinterface

// ----- hw/rtl/msd_out_if.sv -----
// ----------------------------------------------------------------------------
// msd_out_if
// Result channel: debounced channel mask and next mux select value.
// ----------------------------------------------------------------------------
interface msd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] debounced_mask;
  logic [1:0]  select_lines;

  modport source (output valid, output debounced_mask, output select_lines, input ready);
  modport sink   (input valid, input debounced_mask, input select_lines, output ready);
endinterface

// ----- hw/rtl/msd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// msd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface msd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/msd_timer_unit.sv -----
// ----------------------------------------------------------------------------
// msd_timer_unit
// Shared timer arithmetic: saturating decrement by the tick time, or reload
// with the clamped cooldown period. Also flags a timer at zero.
// ----------------------------------------------------------------------------
module msd_timer_unit
  import msd_pkg::*;
(
  input  msd_timer_op_t op,
  input  timer_t        timer_val,
  input  cfg_word_t     tick_time,
  input  cfg_word_t     cooldown,
  output timer_t        result,
  output logic          is_zero
);

  logic [WIDE_BITS-1:0] wide_timer;
  logic [WIDE_BITS-1:0] wide_tick;
  logic [WIDE_BITS-1:0] wide_diff;

  assign wide_timer = WIDE_BITS'(timer_val);
  assign wide_tick  = WIDE_BITS'(tick_time);
  assign wide_diff  = wide_timer - wide_tick;
  assign is_zero    = (timer_val == '0);

  // one subtract/compare, shared by every channel
  always_comb begin
    result = '0;
    case (op)
      TOP_DEC: begin
        if (wide_timer > wide_tick) begin
          result = wide_diff[TIMER_BITS-1:0];
        end
      end
      TOP_LOAD: begin
        result = clamp_timer(cooldown);
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/msd_seq.sv -----
// ----------------------------------------------------------------------------
// msd_seq
// Scan sequencer: sweeps all channel timers, then walks the mux pins, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module msd_seq
  import msd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_free,
  output msd_ctrl_t ctrl
);

  msd_state_t state;
  msd_state_t state_next;
  ch_idx_t    cnt;

  localparam ch_idx_t LAST_CH  = CH_BITS'(CHANNELS - 1);
  localparam ch_idx_t LAST_PIN = CH_BITS'(MUX_PINS - 1);

  // state register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        cnt <= (cnt == LAST_CH) ? '0 : cnt + CH_BITS'(1);
      end else if (state == ST_PINS) begin
        cnt <= (cnt == LAST_PIN) ? '0 : cnt + CH_BITS'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SWEEP;
      ST_SWEEP:  if (cnt == LAST_CH) state_next = ST_PINS;
      ST_PINS:   if (cnt == LAST_PIN) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl          = '0;
    ctrl.idx      = cnt;
    unique case (state)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_SWEEP:  ctrl.sweep    = 1'b1;
      ST_PINS:   ctrl.pin      = 1'b1;
      ST_FINISH: ctrl.load     = out_free;
      default:   ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/muxed_switch_scan_debounce_unit.sv -----
// ----------------------------------------------------------------------------
// muxed_switch_scan_debounce_unit
// Multiplexed switch scanner with a cooldown debounce on each of 32 channels.
// ----------------------------------------------------------------------------
// Each scan transaction runs from acceptance to the next acceptance in
// steps: the pins are taken, the single shared timer subtractor visits every
// channel timer in turn, then it handles the mux pins one by one, and the
// result moves into the output register (a step that waits only while that
// register is still full).
// The result register holds its transaction until taken, so the next scan
// can start before the previous result has been read. Configuration writes
// are always accepted; unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module muxed_switch_scan_debounce_unit
  import msd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  msd_in_if.sink    scan,
  msd_out_if.source result,
  msd_cfg_if.sink   cfg
);

  cfg_word_t tick_time_us;
  cfg_word_t cooldown_period_us;

  timer_t                  cooldown_timer [CHANNELS];
  logic [CHANNELS-1:0]     last_raw_state;
  logic [CHANNELS-1:0]     debounced_state;
  logic [SEL_BITS-1:0]     mux_select;
  logic [MUX_PINS-1:0]     pins;

  logic                    out_valid;
  logic [CHANNELS-1:0]     out_mask;
  logic [SEL_BITS-1:0]     out_select;

  msd_ctrl_t               ctrl;
  msd_timer_op_t           op;
  ch_idx_t                 ch;
  logic [PIN_BITS-1:0]     pin_idx;
  logic                    level;
  timer_t                  alu_result;
  logic                    alu_zero;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_time_us       <= TICK_TIME_RESET;
      cooldown_period_us <= COOLDOWN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TICK_TIME: tick_time_us       <= cfg.data;
        REG_COOLDOWN:  cooldown_period_us <= cfg.data;
        default:       ;
      endcase
    end
  end

  // sequencer
  msd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (scan.valid),
    .out_free (!out_valid || result.ready),
    .ctrl     (ctrl)
  );

  assign scan.ready = ctrl.in_ready;

  // channel address: sweep index, or remapped pin under the current select
  assign pin_idx = ctrl.idx[PIN_BITS-1:0];
  assign ch      = ctrl.pin ? REMAP[{pin_idx, mux_select}] : ctrl.idx;
  assign level   = ~pins[pin_idx];
  assign op      = ctrl.pin ? TOP_LOAD : TOP_DEC;

  msd_timer_unit u_timer (
    .op        (op),
    .timer_val (cooldown_timer[ch]),
    .tick_time (tick_time_us),
    .cooldown  (cooldown_period_us),
    .result    (alu_result),
    .is_zero   (alu_zero)
  );

  // capture pins on acceptance
  always_ff @(posedge clk) begin
    if (scan.valid && ctrl.in_ready) begin
      pins <= scan.raw_pins;
    end
  end

  // channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cooldown_timer[i] <= '0;
      end
      last_raw_state  <= '0;
      debounced_state <= '0;
    end else if (ctrl.sweep) begin
      if (alu_zero) begin
        debounced_state[ch] <= last_raw_state[ch];
      end
      cooldown_timer[ch] <= alu_result;
    end else if (ctrl.pin && (level != last_raw_state[ch])) begin
      if (alu_zero) begin
        debounced_state[ch] <= level;
      end
      cooldown_timer[ch] <= alu_result;
      last_raw_state[ch] <= level;
    end
  end

  // select advance and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mux_select <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.load) begin
        mux_select <= mux_select + SEL_BITS'(1);
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_mask   <= debounced_state;
      out_select <= mux_select + SEL_BITS'(1);
    end
  end

  assign result.valid          = out_valid;
  assign result.debounced_mask = out_mask;
  assign result.select_lines   = out_select;

endmodule

// ----- sim/tb_muxed_switch_scan_debounce_unit.sv -----
// ----------------------------------------------------------------------------
// tb_muxed_switch_scan_debounce_unit
// Self-checking bench for the multiplexed switch scanner. Scan transactions
// are driven through the pin channel, and a cycle-free debounce model
// predicts each result's channel mask and next select value. Results are
// compared in order. The bench covers directed corner cases, register
// extremes, a long result back-pressure stretch and random switch activity
// with contact bounce under three handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_muxed_switch_scan_debounce_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  // register indexes the block does not implement
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = CFG_IDX_BITS'(3);

  localparam cfg_word_t CFG_ALL_ONES  = '1;
  localparam int        MAX_REPORTS   = 10;
  localparam int        DRAIN_CYCLES  = 100;
  localparam int        HOLD_CYCLES   = 600;
  localparam int        RANDOM_SCANS  = 800;

  typedef struct packed {
    logic [CHANNELS-1:0] mask;
    logic [SEL_BITS-1:0] sel;
  } scan_result_t;

  logic clk;
  logic rst;

  msd_in_if  scan_if ();
  msd_out_if res_if ();
  msd_cfg_if cfg_if ();

  muxed_switch_scan_debounce_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // debounce model state and its copy of the registers
  timer_t              chan_timer [CHANNELS];
  logic [CHANNELS-1:0] raw_level;
  logic [CHANNELS-1:0] debounced;
  logic [SEL_BITS-1:0] scan_sel;
  cfg_word_t           tick_us;
  cfg_word_t           cooldown_us;

  scan_result_t expected_results [$];
  int errors;

  // switch activity generator state
  logic [CHANNELS-1:0] switch_closed;
  logic [CHANNELS-1:0] bounce_mask;
  int bounce_left;

  // handshake idling control
  int send_idle_pct;
  int recv_idle_pct;
  int hold_len;
  int hold_seq;
  int hold_seen;
  int hold_left;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // one scan tick of the debounce model
  function automatic scan_result_t debounce_tick(input logic [MUX_PINS-1:0] pins);
    int ch;
    logic lvl;
    timer_t reload;
    scan_result_t r;
    // cooldown reload saturates at the timer width
    if (64'(cooldown_us) > ((64'd1 << TIMER_BITS) - 64'd1)) begin
      reload = '1;
    end else begin
      reload = timer_t'(cooldown_us);
    end
    // expired channels settle, then every timer runs down
    for (int i = 0; i < CHANNELS; i++) begin
      if (chan_timer[i] == '0) begin
        debounced[i] = raw_level[i];
      end
      if (64'(chan_timer[i]) > 64'(tick_us)) begin
        chan_timer[i] = timer_t'(64'(chan_timer[i]) - 64'(tick_us));
      end else begin
        chan_timer[i] = '0;
      end
    end
    // pins under the current select feed their remapped channels
    for (int k = 0; k < MUX_PINS; k++) begin
      ch  = REMAP[k * SELECT_STATES + scan_sel];
      lvl = ~pins[k];
      if (lvl != raw_level[ch]) begin
        if (chan_timer[ch] == '0) begin
          debounced[ch] = lvl;
        end
        chan_timer[ch] = reload;
        raw_level[ch]  = lvl;
      end
    end
    scan_sel = scan_sel + 1'b1;
    r.mask = debounced;
    r.sel  = scan_sel;
    return r;
  endfunction

  // pin levels for the next tick: held switches with bounce, some noise
  function automatic logic [MUX_PINS-1:0] next_scan_pins();
    int ch;
    logic lvl;
    logic [MUX_PINS-1:0] p;
    if ($urandom_range(99) < 10) begin
      return MUX_PINS'($urandom);
    end
    if ($urandom_range(99) < 25) begin
      ch = $urandom_range(CHANNELS - 1);
      switch_closed[ch] = ~switch_closed[ch];
      bounce_mask[ch] = 1'b1;
      bounce_left = $urandom_range(2, 8);
    end
    for (int k = 0; k < MUX_PINS; k++) begin
      ch  = REMAP[k * SELECT_STATES + scan_sel];
      lvl = switch_closed[ch];
      if (bounce_mask[ch] && $urandom_range(99) < 40) begin
        lvl = ~lvl;
      end
      p[k] = ~lvl;
    end
    if (bounce_left > 0) begin
      bounce_left--;
      if (bounce_left == 0) begin
        bounce_mask = '0;
      end
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // send one scan transaction, leaving valid high after acceptance
  task automatic send_scan(input logic [MUX_PINS-1:0] pins);
    while ($urandom_range(99) < send_idle_pct) begin
      scan_if.valid <= 1'b0;
      @(posedge clk);
    end
    scan_if.valid    <= 1'b1;
    scan_if.raw_pins <= pins;
    do @(posedge clk); while (!scan_if.ready);
    expected_results.push_back(debounce_tick(pins));
  endtask

  // stop offering scans and wait for every result to come back
  task automatic wait_idle();
    scan_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input cfg_word_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_TICK_TIME: tick_us = value;
      REG_COOLDOWN:  cooldown_us = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input cfg_word_t tick, input cfg_word_t cool);
    wait_idle();
    write_reg(REG_TICK_TIME, tick);
    write_reg(REG_COOLDOWN, cool);
  endtask

  // mostly cooldowns of a few ticks, so channels both settle and stay blocked
  task automatic pick_random_config();
    int mode;
    cfg_word_t tick;
    cfg_word_t cool;
    mode = $urandom_range(9);
    if (mode < 6) begin
      tick = cfg_word_t'($urandom_range(1, 200));
      cool = cfg_word_t'(tick * $urandom_range(0, 12));
    end else if (mode < 7) begin
      tick = '0;
      cool = cfg_word_t'($urandom_range(0, 5000));
    end else if (mode < 8) begin
      tick = cfg_word_t'($urandom);
      cool = cfg_word_t'($urandom);
    end else begin
      tick = cfg_word_t'($urandom_range(1, 50));
      cool = cfg_word_t'($urandom_range(0, 600));
    end
    configure(tick, cool);
  endtask

  // reset register values: all closed, all open, alternating pins
  task automatic test_reset_defaults();
    repeat (4) send_scan(8'h00);
    repeat (4) send_scan(8'hFF);
    send_scan(8'hAA);
    send_scan(8'h55);
  endtask

  // tick time zero: timers never expire once loaded
  task automatic test_tick_zero();
    configure('0, cfg_word_t'(1));
    repeat (3) send_scan(8'h0F);
    repeat (3) send_scan(8'hF0);
  endtask

  // unknown indexes are ignored, then full-scale and zero register values
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_SPARE_2, CFG_ALL_ONES);
    write_reg(REG_SPARE_3, '0);
    send_scan(8'h3C);
    configure(CFG_ALL_ONES, CFG_ALL_ONES);
    send_scan(8'h00);
    send_scan(8'hFF);
    configure(CFG_ALL_ONES, '0);
    repeat (4) send_scan(8'($urandom));
  endtask

  // result side holds off while scans keep coming, so the block stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(cfg_word_t'(100), cfg_word_t'(300));
    hold_len = HOLD_CYCLES;
    hold_seq++;
    repeat (12) send_scan(next_scan_pins());
  endtask

  // random switch activity under each idling pattern and several settings
  task automatic test_random_activity();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 33; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        pick_random_config();
        repeat (RANDOM_SCANS / 12) send_scan(next_scan_pins());
      end
    end
  endtask

  // result ready with random stalls and requested hold-off stretches
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, mask", '0, res_if.debounced_mask);
      end else begin
        want = expected_results.pop_front();
        if (res_if.debounced_mask !== want.mask) begin
          report_mismatch("debounced_mask", want.mask, res_if.debounced_mask);
        end
        if (res_if.select_lines !== want.sel) begin
          report_mismatch("select_lines", 32'(want.sel), 32'(res_if.select_lines));
        end
      end
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    scan_if.valid    = 1'b0;
    scan_if.raw_pins = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    errors           = 0;
    hold_len         = 0;
    hold_seq         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    send_idle_pct    = 33;
    recv_idle_pct    = 57;
    switch_closed    = '0;
    bounce_mask      = '0;
    bounce_left      = 0;
    tick_us          = TICK_TIME_RESET;
    cooldown_us      = COOLDOWN_RESET;
    raw_level        = '0;
    debounced        = '0;
    scan_sel         = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_timer[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_tick_zero();
    test_register_extremes();
    test_backpressure();
    test_random_activity();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
